### rtl/wsa_pkg.sv
package wsa_pkg;

    // fixed widths of the fields, run sums and datapath registers
    localparam int FIELD_W = 16;
    localparam int WSUM_W  = 32;
    localparam int ASUM_W  = 48;
    localparam int BSUM_W  = 64;
    localparam int PROD_W  = 64;
    localparam int ACC_W   = 128;
    localparam int RAD_W   = 96;
    localparam int ROOT_W  = 48;
    localparam int REM_W   = 50;
    localparam int SUB_W   = 52;
    localparam int ITER_W  = 6;

    // partial products for S*B - A*A
    localparam int PP_STEPS = 6;

    // operand codes for the shared multiplier
    localparam logic [2:0] OP_ZERO = 3'd0;
    localparam logic [2:0] OP_S    = 3'd1;
    localparam logic [2:0] OP_BLO  = 3'd2;
    localparam logic [2:0] OP_BHI  = 3'd3;
    localparam logic [2:0] OP_ALO  = 3'd4;
    localparam logic [2:0] OP_AHI  = 3'd5;

    // product alignment codes
    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_32 = 2'd1;
    localparam logic [1:0] SH_64 = 2'd2;

    typedef struct packed {
        logic [2:0] sel_a;
        logic [2:0] sel_b;
        logic [1:0] shift;
        logic       sub;
    } pp_step_t;

    // schedule of partial products: add S*B, subtract A*A
    function automatic pp_step_t pp_step(input logic [2:0] idx);
        pp_step_t st;
        st = '{sel_a: OP_ZERO, sel_b: OP_ZERO, shift: SH_0, sub: 1'b0};
        case (idx)
            3'd0: st = '{sel_a: OP_S,   sel_b: OP_BLO, shift: SH_0,  sub: 1'b0};
            3'd1: st = '{sel_a: OP_S,   sel_b: OP_BHI, shift: SH_32, sub: 1'b0};
            3'd2: st = '{sel_a: OP_ALO, sel_b: OP_ALO, shift: SH_0,  sub: 1'b1};
            3'd3: st = '{sel_a: OP_ALO, sel_b: OP_AHI, shift: SH_32, sub: 1'b1};
            3'd4: st = '{sel_a: OP_AHI, sel_b: OP_ALO, shift: SH_32, sub: 1'b1};
            3'd5: st = '{sel_a: OP_AHI, sel_b: OP_AHI, shift: SH_64, sub: 1'b1};
            default: st = '{sel_a: OP_ZERO, sel_b: OP_ZERO, shift: SH_0, sub: 1'b0};
        endcase
        return st;
    endfunction

endpackage

### rtl/weighted_stats_accumulator.sv
// Weighted mean and standard deviation over a run of (value, weight) beats.
// Input channel: sample_value, sample_weight, last_sample with in_valid and
// in_stall; a beat is taken when in_valid is high and in_stall is low. The
// beat with last_sample set closes the run. Output channel: one result beat
// per run with out_valid and out_stall.
// The one 32x32 multiplier forms w*x in the accept cycle and w*x*x in the
// next, so a counted beat holds in_stall high through its square step. A
// beat dropped past MAX_ITEMS takes no square step.
// From the closing beat to out_valid: the square step, a wait state, six
// partial products for S*B - A*A on the shared multiplier, each a multiply
// and an accumulate step, 48 square root steps and two 48-step divisions
// on one shared subtractor, and a load step that waits for output room; a
// dropped closing beat skips the square step. in_stall is high throughout.
// The result sits in an output register; a new run is taken while it
// waits. If a second result is ready before the first is taken, the block
// holds it and keeps in_stall high until out_stall drops.
// Reset clears the run sums, the count and the output valid.
module weighted_stats_accumulator #(
    parameter int MAX_ITEMS   = 65535,
    parameter int VALUE_BITS  = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] sample_value,
    input  logic [15:0] sample_weight,
    input  logic        last_sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] mean_value,
    output logic [15:0] max_value,
    output logic [15:0] min_value,
    output logic [15:0] std_dev,
    output logic [31:0] total_weight,
    output logic [15:0] item_count,
    output logic        no_weight,
    output logic        run_overflow
);

    localparam int FW = wsa_pkg::FIELD_W;
    localparam logic [FW-1:0] VALUE_MASK  = FW'((32'd1 << VALUE_BITS) - 32'd1);
    localparam logic [FW-1:0] WEIGHT_MASK = FW'((32'd1 << WEIGHT_BITS) - 32'd1);
    localparam logic [FW-1:0] ITEM_LIMIT  = FW'(MAX_ITEMS);
    localparam logic [3:0] PP_LAST = 4'(2 * wsa_pkg::PP_STEPS - 1);
    localparam logic [wsa_pkg::ITER_W-1:0] ITER_LAST = wsa_pkg::ITER_W'(wsa_pkg::ROOT_W - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_PP   = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_DIVM = 3'd5;
    localparam logic [2:0] ST_DIVS = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]                    state_reg;
    logic [wsa_pkg::WSUM_W-1:0]    s_reg;
    logic [wsa_pkg::ASUM_W-1:0]    a_reg;
    logic [wsa_pkg::BSUM_W-1:0]    b_reg;
    logic [FW-1:0]                 max_reg;
    logic [FW-1:0]                 min_reg;
    logic [FW-1:0]                 cnt_reg;
    logic                          ovf_reg;
    logic                          pend_reg;
    logic [FW-1:0]                 x_reg;
    logic [FW-1:0]                 w_reg;
    logic                          last_reg;
    logic [wsa_pkg::PROD_W-1:0]    prod_reg;
    logic [wsa_pkg::ASUM_W-1:0]    sq_reg;
    logic [wsa_pkg::ACC_W-1:0]     acc_reg;
    logic [3:0]                    pp_reg;
    logic [wsa_pkg::RAD_W-1:0]     rad_reg;
    logic [wsa_pkg::ROOT_W-1:0]    root_reg;
    logic [wsa_pkg::REM_W-1:0]     rem_reg;
    logic [wsa_pkg::ASUM_W-1:0]    dv_reg;
    logic [wsa_pkg::ITER_W-1:0]    it_reg;
    logic                          neg_reg;
    logic [FW-1:0]                 mean_reg;

    logic                          out_valid_reg;
    logic [FW-1:0]                 mean_out_reg;
    logic [FW-1:0]                 max_out_reg;
    logic [FW-1:0]                 min_out_reg;
    logic [FW-1:0]                 sd_out_reg;
    logic [wsa_pkg::WSUM_W-1:0]    tw_out_reg;
    logic [FW-1:0]                 cnt_out_reg;
    logic                          nw_out_reg;
    logic                          ovf_out_reg;

    logic                          in_take;
    logic                          out_take;
    logic                          room;
    logic [FW-1:0]                 x_m;
    logic [FW-1:0]                 w_m;
    wsa_pkg::pp_step_t             step;
    logic [31:0]                   mul_a;
    logic [31:0]                   mul_b;
    logic [wsa_pkg::PROD_W-1:0]    mul_p;
    logic [wsa_pkg::ACC_W-1:0]     addend;
    logic [wsa_pkg::ACC_W-1:0]     acc_next;
    logic [wsa_pkg::SUB_W-1:0]     sub_a;
    logic [wsa_pkg::SUB_W-1:0]     sub_b;
    logic [wsa_pkg::SUB_W:0]       diff;
    logic                          ge;
    logic [wsa_pkg::REM_W-1:0]     rem_next;
    logic [wsa_pkg::ASUM_W-1:0]    dv_next;
    logic                          nw;

    // handshakes
    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign room     = !out_valid_reg || !out_stall;
    assign x_m      = sample_value & VALUE_MASK;
    assign w_m      = sample_weight & WEIGHT_MASK;
    assign nw       = (s_reg == '0);

    // operand pick for the partial product schedule
    function automatic logic [31:0] pick(
        input logic [2:0]                 sel,
        input logic [wsa_pkg::WSUM_W-1:0] s,
        input logic [wsa_pkg::ASUM_W-1:0] a,
        input logic [wsa_pkg::BSUM_W-1:0] b
    );
        logic [31:0] v;
        v = '0;
        case (sel)
            wsa_pkg::OP_S:   v = s;
            wsa_pkg::OP_BLO: v = b[31:0];
            wsa_pkg::OP_BHI: v = b[63:32];
            wsa_pkg::OP_ALO: v = a[31:0];
            wsa_pkg::OP_AHI: v = {16'b0, a[47:32]};
            default:         v = '0;
        endcase
        return v;
    endfunction

    // shared multiplier
    assign step = wsa_pkg::pp_step(pp_reg[3:1]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_IDLE:
            begin
                mul_a = {16'b0, w_m};
                mul_b = {16'b0, x_m};
            end
            ST_SQ:
            begin
                mul_a = prod_reg[31:0];
                mul_b = {16'b0, x_reg};
            end
            ST_PP:
            begin
                mul_a = pick(step.sel_a, s_reg, a_reg, b_reg);
                mul_b = pick(step.sel_b, s_reg, a_reg, b_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // aligned accumulate of the registered product
    always_comb
    begin
        addend = {64'b0, prod_reg};
        case (step.shift)
            wsa_pkg::SH_32: addend = {64'b0, prod_reg} << 32;
            wsa_pkg::SH_64: addend = {64'b0, prod_reg} << 64;
            default:        addend = {64'b0, prod_reg};
        endcase
        acc_next = step.sub ? (acc_reg - addend) : (acc_reg + addend);
    end

    // shared subtractor for root and division steps
    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            sub_a = {rem_reg, rad_reg[95:94]};
            sub_b = {2'b00, root_reg, 2'b01};
        end
        else
        begin
            sub_a = {19'b0, rem_reg[31:0], dv_reg[47]};
            sub_b = {20'b0, s_reg};
        end
        diff     = {1'b0, sub_a} - {1'b0, sub_b};
        ge       = !diff[wsa_pkg::SUB_W];
        rem_next = ge ? diff[wsa_pkg::REM_W-1:0] : sub_a[wsa_pkg::REM_W-1:0];
        dv_next  = {dv_reg[46:0], ge};
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            max_reg       <= '0;
            min_reg       <= '1;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            pp_reg        <= '0;
            it_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // deferred add of w*x*x
            pend_reg <= (state_reg == ST_SQ);
            if (pend_reg)
            begin
                b_reg <= b_reg + {16'b0, sq_reg};
            end

            if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        if (cnt_reg < ITEM_LIMIT)
                        begin
                            prod_reg  <= mul_p;
                            x_reg     <= x_m;
                            w_reg     <= w_m;
                            last_reg  <= last_sample;
                            state_reg <= ST_SQ;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                            if (last_sample)
                            begin
                                state_reg <= ST_FIN;
                            end
                        end
                    end
                end
                ST_SQ:
                begin
                    s_reg   <= s_reg + {16'b0, w_reg};
                    a_reg   <= a_reg + {16'b0, prod_reg[31:0]};
                    sq_reg  <= mul_p[wsa_pkg::ASUM_W-1:0];
                    cnt_reg <= cnt_reg + 1'b1;
                    if (x_reg > max_reg)
                    begin
                        max_reg <= x_reg;
                    end
                    if (x_reg < min_reg)
                    begin
                        min_reg <= x_reg;
                    end
                    state_reg <= last_reg ? ST_FIN : ST_IDLE;
                end
                ST_FIN:
                begin
                    acc_reg   <= '0;
                    pp_reg    <= '0;
                    state_reg <= ST_PP;
                end
                ST_PP:
                begin
                    // even step multiplies, odd step accumulates
                    if (!pp_reg[0])
                    begin
                        prod_reg <= mul_p;
                    end
                    else
                    begin
                        acc_reg <= acc_next;
                    end
                    pp_reg <= pp_reg + 1'b1;
                    if (pp_reg == PP_LAST)
                    begin
                        rad_reg   <= acc_next[wsa_pkg::RAD_W-1:0];
                        neg_reg   <= acc_next[wsa_pkg::ACC_W-1];
                        root_reg  <= '0;
                        rem_reg   <= '0;
                        it_reg    <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    rem_reg  <= rem_next;
                    root_reg <= {root_reg[wsa_pkg::ROOT_W-2:0], ge};
                    rad_reg  <= rad_reg << 2;
                    it_reg   <= it_reg + 1'b1;
                    if (it_reg == ITER_LAST)
                    begin
                        dv_reg    <= a_reg;
                        rem_reg   <= '0;
                        it_reg    <= '0;
                        state_reg <= ST_DIVM;
                    end
                end
                ST_DIVM:
                begin
                    rem_reg <= rem_next;
                    dv_reg  <= dv_next;
                    it_reg  <= it_reg + 1'b1;
                    if (it_reg == ITER_LAST)
                    begin
                        mean_reg  <= dv_next[FW-1:0];
                        dv_reg    <= root_reg;
                        rem_reg   <= '0;
                        it_reg    <= '0;
                        state_reg <= ST_DIVS;
                    end
                end
                ST_DIVS:
                begin
                    rem_reg <= rem_next;
                    dv_reg  <= dv_next;
                    it_reg  <= it_reg + 1'b1;
                    if (it_reg == ITER_LAST)
                    begin
                        it_reg    <= '0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (room)
                    begin
                        out_valid_reg <= 1'b1;
                        mean_out_reg  <= nw ? '0 : mean_reg;
                        sd_out_reg    <= (nw || neg_reg) ? '0 : dv_reg[FW-1:0];
                        max_out_reg   <= (cnt_reg != '0) ? max_reg : '0;
                        min_out_reg   <= (cnt_reg != '0) ? min_reg : '0;
                        tw_out_reg    <= s_reg;
                        cnt_out_reg   <= cnt_reg;
                        nw_out_reg    <= nw;
                        ovf_out_reg   <= ovf_reg;
                        // start a fresh run
                        s_reg         <= '0;
                        a_reg         <= '0;
                        b_reg         <= '0;
                        max_reg       <= '0;
                        min_reg       <= '1;
                        cnt_reg       <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result port
    assign out_valid    = out_valid_reg;
    assign mean_value   = mean_out_reg;
    assign max_value    = max_out_reg;
    assign min_value    = min_out_reg;
    assign std_dev      = sd_out_reg;
    assign total_weight = tw_out_reg;
    assign item_count   = cnt_out_reg;
    assign no_weight    = nw_out_reg;
    assign run_overflow = ovf_out_reg;

    // checks
    a_sq_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ) |-> $past(in_valid && !in_stall))
        else $error("square step without a taken beat");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ITEM_LIMIT)
        else $error("item count past limit");

    a_no_pending_in_pp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PP) |-> !pend_reg)
        else $error("square sum not settled before products");

    a_no_weight_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && nw_out_reg) |-> (mean_out_reg == '0 && sd_out_reg == '0))
        else $error("zero weight result not cleared");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        it_reg <= ITER_LAST)
        else $error("iteration counter out of range");

endmodule

### test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RUN     = 65535;
    localparam int CYCLE_LIMIT = 3000000;

    // one expected run summary
    typedef struct {
        logic [15:0] mean;
        logic [15:0] peak;
        logic [15:0] floor_v;
        logic [15:0] spread;
        logic [31:0] weight;
        logic [15:0] count;
        logic        nw;
        logic        ovf;
    } run_summary_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] sample_value = 16'd0;
    logic [15:0] sample_weight = 16'd0;
    logic        last_sample = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] mean_value;
    logic [15:0] max_value;
    logic [15:0] min_value;
    logic [15:0] std_dev;
    logic [31:0] total_weight;
    logic [15:0] item_count;
    logic        no_weight;
    logic        run_overflow;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;

    // running sums of the open run
    logic [31:0] acc_weight;
    logic [47:0] acc_wx;
    logic [63:0] acc_wxx;
    logic [15:0] acc_max;
    logic [15:0] acc_min;
    logic [15:0] acc_count;
    logic        acc_over;

    run_summary_t pending_summaries[$];

    weighted_stats_accumulator #(
        .MAX_ITEMS(MAX_RUN),
        .VALUE_BITS(16),
        .WEIGHT_BITS(16)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample_value(sample_value),
        .sample_weight(sample_weight),
        .last_sample(last_sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .mean_value(mean_value),
        .max_value(max_value),
        .min_value(min_value),
        .std_dev(std_dev),
        .total_weight(total_weight),
        .item_count(item_count),
        .no_weight(no_weight),
        .run_overflow(run_overflow)
    );

    always #5 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // random receiver stall
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    task automatic clear_run_state();
        acc_weight = 32'd0;
        acc_wx = 48'd0;
        acc_wxx = 64'd0;
        acc_max = 16'd0;
        acc_min = 16'hFFFF;
        acc_count = 16'd0;
        acc_over = 1'b0;
    endtask

    // fold one accepted beat into the sums, close the run on the last beat
    task automatic fold_sample(input logic [15:0] v, input logic [15:0] w, input logic l);
        run_summary_t s;
        logic [63:0]  wx;
        logic [127:0] sb;
        logic [127:0] aa;
        logic [127:0] diff;
        logic [127:0] cand_sq;
        logic [63:0]  root;
        logic [63:0]  cand;
        logic [47:0]  mean_q;
        logic [63:0]  spread_q;
        if (acc_count < MAX_RUN)
        begin
            wx = {48'd0, w} * {48'd0, v};
            acc_weight = acc_weight + {16'd0, w};
            acc_wx = acc_wx + wx[47:0];
            acc_wxx = acc_wxx + wx * {48'd0, v};
            if (v > acc_max)
                acc_max = v;
            if (v < acc_min)
                acc_min = v;
            acc_count = acc_count + 16'd1;
        end
        else
            acc_over = 1'b1;
        if (l)
        begin
            s.mean = 16'd0;
            s.spread = 16'd0;
            s.nw = (acc_weight == 32'd0);
            if (!s.nw)
            begin
                sb = {96'd0, acc_weight} * {64'd0, acc_wxx};
                aa = {80'd0, acc_wx} * {80'd0, acc_wx};
                mean_q = acc_wx / {16'd0, acc_weight};
                s.mean = mean_q[15:0];
                if (aa <= sb)
                begin
                    // bitwise integer square root of S*B - A*A
                    diff = sb - aa;
                    root = 64'd0;
                    for (int bit_idx = 63; bit_idx >= 0; bit_idx--)
                    begin
                        cand = root | (64'd1 << bit_idx);
                        cand_sq = {64'd0, cand} * {64'd0, cand};
                        if (cand_sq <= diff)
                            root = cand;
                    end
                    spread_q = root / {32'd0, acc_weight};
                    s.spread = spread_q[15:0];
                end
            end
            s.peak = (acc_count != 16'd0) ? acc_max : 16'd0;
            s.floor_v = (acc_count != 16'd0) ? acc_min : 16'd0;
            s.weight = acc_weight;
            s.count = acc_count;
            s.ovf = acc_over;
            pending_summaries.push_back(s);
            clear_run_state();
        end
    endtask

    // drive one beat and wait for it to be taken
    task automatic send_sample(input logic [15:0] v, input logic [15:0] w, input logic l);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_value <= v;
        sample_weight <= w;
        last_sample <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        fold_sample(v, w, l);
    endtask

    // hold the sender off until every pending summary has come out
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_summaries.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 15));
            3: return 16'($urandom_range(65500, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    // weight mode 0: all zero, 1: all full scale, else mixed
    function automatic logic [15:0] pick_weight(input int mode);
        if (mode == 0)
            return 16'd0;
        if (mode == 1)
            return 16'hFFFF;
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // compare each taken result beat with the oldest summary
    always @(posedge clk)
    begin : check_results
        run_summary_t s;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_summaries.size() == 0)
            begin
                $error("result beat with no run pending");
                mismatches++;
            end
            else
            begin
                s = pending_summaries.pop_front();
                check_field("mean_value", {16'd0, s.mean}, {16'd0, mean_value});
                check_field("max_value", {16'd0, s.peak}, {16'd0, max_value});
                check_field("min_value", {16'd0, s.floor_v}, {16'd0, min_value});
                check_field("std_dev", {16'd0, s.spread}, {16'd0, std_dev});
                check_field("total_weight", s.weight, total_weight);
                check_field("item_count", {16'd0, s.count}, {16'd0, item_count});
                check_field("no_weight", {31'd0, s.nw}, {31'd0, no_weight});
                check_field("run_overflow", {31'd0, s.ovf}, {31'd0, run_overflow});
            end
        end
    end

    // field extremes, zero weight sums, bit patterns
    task automatic test_directed_runs();
        // single beat, zero weight
        send_sample(16'd0, 16'd0, 1'b1);
        // single beat, full scale
        send_sample(16'hFFFF, 16'hFFFF, 1'b1);
        // wide spread
        send_sample(16'hFFFF, 16'd1, 1'b0);
        send_sample(16'd0, 16'hFFFF, 1'b0);
        send_sample(16'h8000, 16'hFFFF, 1'b1);
        // zero weight sum still reports max, min and count
        send_sample(16'd100, 16'd0, 1'b0);
        send_sample(16'hFFFF, 16'd0, 1'b0);
        send_sample(16'd7, 16'd0, 1'b1);
        // alternating bits
        send_sample(16'hAAAA, 16'h5555, 1'b0);
        send_sample(16'h5555, 16'hAAAA, 1'b1);
        // largest deviation
        send_sample(16'd0, 16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 16'hFFFF, 1'b1);
        // equal values give zero deviation
        send_sample(16'd1234, 16'd1, 1'b0);
        send_sample(16'd1234, 16'hFFFF, 1'b1);
        // zero weight beat still moves the max
        send_sample(16'hFFFF, 16'd0, 1'b0);
        send_sample(16'd3, 16'd5, 1'b1);
    endtask

    // random runs of mostly short length
    task automatic test_random_runs(input int item_budget);
        int sent;
        int len;
        int wmode;
        sent = 0;
        while (sent < item_budget)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
                6, 7: len = $urandom_range(5, 16);
                8: len = $urandom_range(17, 60);
                default: len = 1;
            endcase
            wmode = $urandom_range(0, 11);
            if ($urandom_range(0, 29) == 0)
                wait_for_drain();
            for (int k = 0; k < len; k++)
                send_sample(pick_value(), pick_weight(wmode), k == len - 1);
            sent += len;
        end
    endtask

    initial
    begin
        clear_run_state();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender idles lightly, receiver stalls often
        sender_idle_pct = 11;
        receiver_stall_pct = 46;
        test_directed_runs();
        test_random_runs(384);
        wait_for_drain();

        // sender idles often, receiver stalls lightly
        sender_idle_pct = 46;
        receiver_stall_pct = 11;
        test_random_runs(384);
        wait_for_drain();

        // no idling on either side
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        test_random_runs(384);
        wait_for_drain();

        // let any stray result show up
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
